// File: hdl/bbec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbec_pkg
// Shared constants and helpers for the byte block entropy classifier.
// ----------------------------------------------------------------------------
package bbec_pkg;

  localparam int unsigned BLOCK_MAX_DEF     = 1024;
  localparam int unsigned LOG_FRAC_BITS_DEF = 16;

  // Mantissa of the log unit holds 30 fraction bits in a 32-bit word.
  localparam int unsigned MANT_FRAC = 30;
  localparam int unsigned MANT_W    = 32;

  localparam logic [3:0] KIND_ZERO       = 4'd0;
  localparam logic [3:0] KIND_FF         = 4'd1;
  localparam logic [3:0] KIND_TEXT       = 4'd2;
  localparam logic [3:0] KIND_SPARSE     = 4'd3;
  localparam logic [3:0] KIND_REPEAT     = 4'd4;
  localparam logic [3:0] KIND_LOW_H      = 4'd5;
  localparam logic [3:0] KIND_MID_H      = 4'd6;
  localparam logic [3:0] KIND_DENSE      = 4'd7;
  localparam logic [3:0] KIND_HIGH_H     = 4'd8;
  localparam logic [3:0] KIND_UNREADABLE = 4'd9;
  localparam logic [3:0] KIND_SINGLE00   = 4'd10;
  localparam logic [3:0] KIND_SINGLEBYTE = 4'd11;

  localparam logic [3:0] COLOR_ZERO   = 4'd0;
  localparam logic [3:0] COLOR_FF     = 4'd1;
  localparam logic [3:0] COLOR_HIGH_H = 4'd2;
  localparam logic [3:0] COLOR_REPEAT = 4'd3;
  localparam logic [3:0] COLOR_LOW_H  = 4'd4;
  localparam logic [3:0] COLOR_MID_H  = 4'd5;
  localparam logic [3:0] COLOR_TEXT   = 4'd6;
  localparam logic [3:0] COLOR_DENSE  = 4'd7;
  localparam logic [3:0] COLOR_SPARSE = 4'd8;

  localparam int unsigned USED_REPEAT_MAX = 4;

  // Palette for a lone non-text byte, indexed by (b * 6) / 256.
  function automatic logic [3:0] single_color(input logic [7:0] b);
    logic [10:0] prod;
    prod = 11'(b) * 11'd6;
    case (prod[10:8])
      3'd0:    single_color = COLOR_REPEAT;
      3'd1:    single_color = COLOR_LOW_H;
      3'd2:    single_color = COLOR_MID_H;
      3'd3:    single_color = COLOR_HIGH_H;
      3'd4:    single_color = COLOR_DENSE;
      default: single_color = COLOR_SPARSE;
    endcase
  endfunction

  function automatic logic is_printable(input logic [7:0] b);
    is_printable = (b == 8'd9) || (b == 8'd10) || (b == 8'd13) ||
                   ((b >= 8'd32) && (b <= 8'd126));
  endfunction

endpackage
`default_nettype wire

// File: hdl/byte_block_entropy_classifier_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_block_entropy_classifier_top
// Histogram a block of bytes and classify it by content and entropy.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one byte per transfer,
//   with byte_valid_i, last_of_block_i and single_byte_mode_i. Output
//   channel (out_valid_o / out_ready_i) carries one color/kind result per
//   block, on the transfer that held the last marker.
//   Each counted byte is one histogram memory read, then one write
//   back. An item with no byte takes no write back.
//   At the end of a block a sequencer walks all 256 bins (an empty bin is
//   read and skipped; a used bin goes through the shared log unit, one
//   squaring multiply per fraction bit), computes log2(n), then divides
//   the sum one quotient bit per cycle.
//   The walk also clears each bin. A per-byte result still sweeps 256 bins.
//   Reset runs a clearing pass over all 256 bins of the histogram memory; the
//   input is not ready during it.
//   A finished result sits in the output register; if the receiver stalls,
//   the next block is still taken in, then its result waits, input not ready.
// ----------------------------------------------------------------------------
module byte_block_entropy_classifier_top #(
  parameter int unsigned BlockMax    = bbec_pkg::BLOCK_MAX_DEF,
  parameter int unsigned LogFracBits = bbec_pkg::LOG_FRAC_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       byte_valid_i,
  input  wire logic       last_of_block_i,
  input  wire logic       single_byte_mode_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      color_index_o,
  output logic [3:0]      kind_code_o
);
  import bbec_pkg::*;

  localparam int unsigned CW  = $clog2(BlockMax + 1);   // count width
  localparam int unsigned KW  = $clog2(CW + 1);         // log integer width
  localparam int unsigned LW  = KW + LogFracBits;       // log value width
  localparam int unsigned SW  = CW + LW;                // sum width
  localparam int unsigned HW  = LW + 3;                 // entropy compare width
  localparam int unsigned FCW = $clog2(LogFracBits);
  localparam int unsigned DCW = $clog2(SW);
  localparam int unsigned XW  = CW + MANT_FRAC;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_UPD   = 4'd2;
  localparam logic [3:0] S_WRD   = 4'd3;
  localparam logic [3:0] S_WCHK  = 4'd4;
  localparam logic [3:0] S_LNORM = 4'd5;
  localparam logic [3:0] S_LSQ   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_ADD   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  localparam logic [HW-1:0] TH_2  = HW'(2)  << LogFracBits;
  localparam logic [HW-1:0] TH_4  = HW'(4)  << LogFracBits;
  localparam logic [HW-1:0] TH_55 = HW'(11) << (LogFracBits - 1);
  localparam logic [HW-1:0] TH_7  = HW'(7)  << LogFracBits;

  // Histogram memory.
  logic [CW-1:0] hist_mem [256];
  logic [CW-1:0] rdata_q;
  logic [7:0]    rd_addr;
  logic          wr_en;
  logic [7:0]    wr_addr;
  logic [CW-1:0] wr_data;

  logic [3:0]     state_q;
  logic [7:0]     idx_q;
  logic [7:0]     byte_q;
  logic [7:0]     first_q;
  logic           last_q;
  logic           single_q;
  logic           pend_q;
  logic [CW-1:0]  total_q, zero_q, ones_q, print_q;
  logic [2:0]     used_q;
  logic [CW-1:0]  h_q;
  logic [CW-1:0]  log_x_q;
  logic           log_n_q;
  logic [KW-1:0]  k_q;
  logic [MANT_W-1:0]    m_q;
  logic [LogFracBits-1:0] frac_q;
  logic [FCW-1:0] fcnt_q;
  logic [LW-1:0]  ln_q;
  logic [SW-1:0]  prod_q;
  logic [SW-1:0]  sum_q;
  logic [CW-1:0]  rem_q;
  logic [DCW-1:0] dcnt_q;
  logic           out_valid_q;
  logic [3:0]     color_q, kind_q;

  logic           accept;
  logic           count_en;
  logic           emit_load;

  assign accept    = in_valid_i && in_ready_o;
  assign count_en  = byte_valid_i && (total_q < CW'(BlockMax));
  // Load the output register once it is empty or being drained.
  assign emit_load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign color_index_o = color_q;
  assign kind_code_o   = kind_q;

  assign rd_addr = (state_q == S_IDLE) ? data_byte_i : idx_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = '0;
    unique case (state_q)
      S_UPD: begin
        wr_en   = 1'b1;
        wr_addr = byte_q;
        wr_data = rdata_q + CW'(1);
      end
      S_WCHK, S_CLR: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    rdata_q <= hist_mem[rd_addr];
  end

  // Leading-one position of the log operand.
  function automatic logic [KW-1:0] msb_pos(input logic [CW-1:0] x);
    msb_pos = '0;
    for (int i = 0; i < int'(CW); i++) begin
      if (x[i]) msb_pos = KW'(i);
    end
  endfunction

  logic [KW-1:0]      norm_k;
  logic [XW-1:0]      norm_x;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W-1:0]  sq_shift;
  logic [CW:0]        rem_try;
  logic [CW:0]        rem_sub;

  assign norm_k   = msb_pos(log_x_q);
  assign norm_x   = {log_x_q, MANT_FRAC'(0)} >> norm_k;
  assign sq       = m_q * m_q;
  assign sq_shift = sq[MANT_FRAC +: MANT_W];
  assign rem_try  = {rem_q, sum_q[SW-1]};
  assign rem_sub  = rem_try - {1'b0, total_q};

  // Final class from the stored counts and the quotient.
  logic [HW-1:0] h_ent;
  logic [CW+4:0] print20, n17, zero4, n3;
  logic [3:0]    res_color, res_kind;

  always_comb begin
    h_ent   = (SW'(ln_q) > sum_q) ? HW'(ln_q - sum_q[LW-1:0]) : '0;
    print20 = (CW+5)'(print_q) * (CW+5)'(20);
    n17     = (CW+5)'(total_q) * (CW+5)'(17);
    zero4   = (CW+5)'(zero_q) << 2;
    n3      = (CW+5)'(total_q) * (CW+5)'(3);
    if (total_q == '0) begin
      res_color = COLOR_SPARSE; res_kind = KIND_UNREADABLE;
    end else if (single_q) begin
      if (first_q == 8'd0) begin
        res_color = COLOR_ZERO; res_kind = KIND_SINGLE00;
      end else if (first_q == 8'd255) begin
        res_color = COLOR_FF; res_kind = KIND_FF;
      end else if ((first_q >= 8'd32) && (first_q <= 8'd126)) begin
        res_color = COLOR_TEXT; res_kind = KIND_TEXT;
      end else begin
        res_color = single_color(first_q); res_kind = KIND_SINGLEBYTE;
      end
    end else if (zero_q == total_q) begin
      res_color = COLOR_ZERO; res_kind = KIND_ZERO;
    end else if (ones_q == total_q) begin
      res_color = COLOR_FF; res_kind = KIND_FF;
    end else if (print20 >= n17) begin
      res_color = COLOR_TEXT; res_kind = KIND_TEXT;
    end else if (zero4 >= n3) begin
      res_color = COLOR_SPARSE; res_kind = KIND_SPARSE;
    end else if ((used_q <= 3'(USED_REPEAT_MAX)) || (h_ent < TH_2)) begin
      res_color = COLOR_REPEAT; res_kind = KIND_REPEAT;
    end else if (h_ent < TH_4) begin
      res_color = COLOR_LOW_H; res_kind = KIND_LOW_H;
    end else if (h_ent < TH_55) begin
      res_color = COLOR_MID_H; res_kind = KIND_MID_H;
    end else if (h_ent < TH_7) begin
      res_color = COLOR_DENSE; res_kind = KIND_DENSE;
    end else begin
      res_color = COLOR_HIGH_H; res_kind = KIND_HIGH_H;
    end
  end

  // Block end: empty goes straight out, single byte only clears, else walk.
  logic [3:0] end_state;
  assign end_state = (total_q == '0) ? S_EMIT : (single_q ? S_CLR : S_WRD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      idx_q       <= '0;
      byte_q      <= '0;
      first_q     <= '0;
      last_q      <= 1'b0;
      single_q    <= 1'b0;
      pend_q      <= 1'b0;
      total_q     <= '0;
      zero_q      <= '0;
      ones_q      <= '0;
      print_q     <= '0;
      used_q      <= '0;
      h_q         <= '0;
      log_x_q     <= '0;
      log_n_q     <= 1'b0;
      k_q         <= '0;
      m_q         <= '0;
      frac_q      <= '0;
      fcnt_q      <= '0;
      ln_q        <= '0;
      prod_q      <= '0;
      sum_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      color_q     <= '0;
      kind_q      <= '0;
    end else begin
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          idx_q <= idx_q + 8'd1;
          if (idx_q == 8'd255) begin
            state_q <= pend_q ? S_EMIT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            byte_q   <= data_byte_i;
            last_q   <= last_of_block_i;
            single_q <= single_byte_mode_i;
            idx_q    <= '0;
            sum_q    <= '0;
            used_q   <= '0;
            if (count_en) begin
              if (total_q == '0) first_q <= data_byte_i;
              total_q <= total_q + CW'(1);
              if (data_byte_i == 8'd0)   zero_q  <= zero_q + CW'(1);
              if (data_byte_i == 8'd255) ones_q  <= ones_q + CW'(1);
              if (is_printable(data_byte_i)) print_q <= print_q + CW'(1);
              state_q <= S_UPD;
            end else if (last_of_block_i) begin
              pend_q  <= 1'b1;
              state_q <= (total_q == '0) ? S_EMIT :
                         (single_byte_mode_i ? S_CLR : S_WRD);
            end
          end
        end
        S_UPD: begin
          if (last_q) begin
            pend_q  <= 1'b1;
            state_q <= end_state;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_WRD: state_q <= S_WCHK;
        S_WCHK: begin
          if (rdata_q != '0) begin
            h_q     <= rdata_q;
            log_x_q <= rdata_q;
            log_n_q <= 1'b0;
            if (used_q != 3'(USED_REPEAT_MAX + 1)) used_q <= used_q + 3'd1;
            state_q <= S_LNORM;
          end else if (idx_q == 8'd255) begin
            log_x_q <= total_q;
            log_n_q <= 1'b1;
            state_q <= S_LNORM;
          end else begin
            idx_q   <= idx_q + 8'd1;
            state_q <= S_WRD;
          end
        end
        S_LNORM: begin
          k_q     <= norm_k;
          m_q     <= norm_x[MANT_W-1:0];
          frac_q  <= '0;
          fcnt_q  <= '0;
          state_q <= S_LSQ;
        end
        S_LSQ: begin
          // Square the mantissa; a carry into bit 31 yields a one bit.
          if (sq_shift[MANT_W-1]) begin
            m_q    <= sq_shift >> 1;
            frac_q <= {frac_q[LogFracBits-2:0], 1'b1};
          end else begin
            m_q    <= sq_shift;
            frac_q <= {frac_q[LogFracBits-2:0], 1'b0};
          end
          fcnt_q <= fcnt_q + FCW'(1);
          if (fcnt_q == FCW'(LogFracBits - 1)) begin
            if (log_n_q) begin
              ln_q    <= {k_q, frac_q[LogFracBits-2:0], sq_shift[MANT_W-1]};
              rem_q   <= '0;
              dcnt_q  <= '0;
              state_q <= S_DIV;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= SW'(h_q) * SW'({k_q, frac_q});
          state_q <= S_ADD;
        end
        S_ADD: begin
          sum_q <= sum_q + prod_q;
          if (idx_q == 8'd255) begin
            log_x_q <= total_q;
            log_n_q <= 1'b1;
            state_q <= S_LNORM;
          end else begin
            idx_q   <= idx_q + 8'd1;
            state_q <= S_WRD;
          end
        end
        S_DIV: begin
          // Restoring divide: one quotient bit per cycle into the sum word.
          if (!rem_sub[CW]) begin
            rem_q <= rem_sub[CW-1:0];
            sum_q <= {sum_q[SW-2:0], 1'b1};
          end else begin
            rem_q <= rem_try[CW-1:0];
            sum_q <= {sum_q[SW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q + DCW'(1);
          if (dcnt_q == DCW'(SW - 1)) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            color_q     <= res_color;
            kind_q      <= res_kind;
            pend_q      <= 1'b0;
            total_q     <= '0;
            zero_q      <= '0;
            ones_q      <= '0;
            print_q     <= '0;
            first_q     <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(BlockMax))
    else $error("byte count beyond block limit");

  a_sub_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (zero_q <= total_q) && (ones_q <= total_q) && (print_q <= total_q))
    else $error("class count exceeds byte count");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (kind_q <= KIND_SINGLEBYTE) && (color_q <= COLOR_SPARSE))
    else $error("result code out of range");

  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && (!out_valid_q || out_ready_i) |=>
      out_valid_q && (state_q == S_IDLE))
    else $error("result not loaded on emit");

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte block entropy classifier testbench
// Streams directed and random byte blocks into the classifier, predicts each
// block's color and kind with a fixed-point entropy model, and compares every
// result transfer in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import bbec_pkg::*;

  localparam int unsigned BLK_MAX = BLOCK_MAX_DEF;
  localparam int unsigned FRAC    = LOG_FRAC_BITS_DEF;

  typedef struct packed {
    logic [3:0] color;
    logic [3:0] kind;
  } class_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_flag;
  logic       single_mode;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] color_index;
  logic [3:0] kind_code;

  // Block state mirrored by the predictor.
  int unsigned hist[256];
  int unsigned n_bytes, n_zero, n_ones, n_print;
  logic [7:0]  lead_byte;

  class_t      class_q[$];
  int unsigned fail_count;
  int unsigned hold_off;   // forced receiver stall, in cycles
  bit          stall_en;

  byte_block_entropy_classifier_top DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .data_byte_i        (data_byte),
    .byte_valid_i       (byte_valid),
    .last_of_block_i    (last_flag),
    .single_byte_mode_i (single_mode),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .color_index_o      (color_index),
    .kind_code_o        (kind_code)
  );

  always #5 clk = ~clk;

  // Fixed-point log2 by repeated squaring of the normalized mantissa.
  function automatic longint unsigned log2_fx(input int unsigned x);
    int unsigned       k;
    longint unsigned   m;
    longint unsigned   frac;
    k = 0;
    frac = 0;
    if (x == 0) return 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = (longint'(x) << 30) >> k;
    for (int i = 0; i < FRAC; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(k) << FRAC) | frac;
  endfunction

  function automatic class_t lone_byte_class(input logic [7:0] b);
    class_t r;
    int unsigned band;
    band = (int'(b) * 6) / 256;
    if (b == 8'h00)                 r = '{COLOR_ZERO, KIND_SINGLE00};
    else if (b == 8'hFF)            r = '{COLOR_FF, KIND_FF};
    else if (b >= 32 && b <= 126)   r = '{COLOR_TEXT, KIND_TEXT};
    else begin
      case (band)
        0: r.color = COLOR_REPEAT;
        1: r.color = COLOR_LOW_H;
        2: r.color = COLOR_MID_H;
        3: r.color = COLOR_HIGH_H;
        4: r.color = COLOR_DENSE;
        default: r.color = COLOR_SPARSE;
      endcase
      r.kind = KIND_SINGLEBYTE;
    end
    return r;
  endfunction

  function automatic class_t block_class();
    longint unsigned n, acc, ln, q, h;
    int unsigned used;
    class_t r;
    n = n_bytes;
    acc = 0;
    used = 0;
    for (int i = 0; i < 256; i++) begin
      if (hist[i] != 0) begin
        used++;
        acc += longint'(hist[i]) * log2_fx(hist[i]);
      end
    end
    ln = log2_fx(n_bytes);
    q = acc / n;
    h = (ln > q) ? ln - q : 0;
    if (n_zero == n)                        r = '{COLOR_ZERO, KIND_ZERO};
    else if (n_ones == n)                   r = '{COLOR_FF, KIND_FF};
    else if (20 * longint'(n_print) >= 17 * n) r = '{COLOR_TEXT, KIND_TEXT};
    else if (4 * longint'(n_zero) >= 3 * n) r = '{COLOR_SPARSE, KIND_SPARSE};
    else if (used <= USED_REPEAT_MAX || h < (64'd2 << FRAC))
      r = '{COLOR_REPEAT, KIND_REPEAT};
    else if (h < (64'd4 << FRAC))           r = '{COLOR_LOW_H, KIND_LOW_H};
    else if (h < (64'd11 << (FRAC - 1)))    r = '{COLOR_MID_H, KIND_MID_H};
    else if (h < (64'd7 << FRAC))           r = '{COLOR_DENSE, KIND_DENSE};
    else                                    r = '{COLOR_HIGH_H, KIND_HIGH_H};
    return r;
  endfunction

  function automatic void clear_block();
    foreach (hist[i]) hist[i] = 0;
    n_bytes = 0; n_zero = 0; n_ones = 0; n_print = 0; lead_byte = 0;
  endfunction

  function automatic bit is_printable_ref(input logic [7:0] b);
    return b == 9 || b == 10 || b == 13 || (b >= 32 && b <= 126);
  endfunction

  // Update the mirrored histogram for one accepted item; queue a result on the last.
  function automatic void predict_item(input logic [7:0] b, input logic v,
                                       input logic l, input logic s);
    if (v && n_bytes < BLK_MAX) begin
      if (n_bytes == 0) lead_byte = b;
      hist[b]++;
      n_bytes++;
      if (b == 8'h00) n_zero++;
      if (b == 8'hFF) n_ones++;
      if (is_printable_ref(b)) n_print++;
    end
    if (!l) return;
    if (n_bytes == 0)  class_q.push_back('{COLOR_SPARSE, KIND_UNREADABLE});
    else if (s)        class_q.push_back(lone_byte_class(lead_byte));
    else               class_q.push_back(block_class());
    clear_block();
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
  endfunction

  // Offer one item, hold it until transferred, then predict.
  task automatic send_item(input logic [7:0] b, input logic v, input logic l,
                           input logic s, input bit idle = 1);
    int unsigned g;
    g = (idle && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    byte_valid  <= v;
    last_flag   <= l;
    single_mode <= s;
    do @(posedge clk); while (!in_ready);
    predict_item(b, v, l, s);
  endtask

  task automatic send_block(input int unsigned len, input int unsigned style,
                            input logic s = 1'b0);
    logic [7:0] b;
    logic [7:0] pal[8];
    foreach (pal[i]) pal[i] = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: b = 8'($urandom);
        1: b = pal[$urandom_range(0, 1)];
        2: b = pal[$urandom_range(0, 7)];
        3: b = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom);
        4: b = 8'($urandom_range(32, 126));
        5: b = 8'($urandom_range(0, 63));
        default: b = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
      endcase
      send_item(b, 1'b1, i == len - 1, s);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (class_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1, 1'b0);   // empty block is unreadable
    send_item(8'h00, 1'b0, 1'b1, 1'b1);   // ... even in per-byte mode
    send_item(8'h00, 1'b1, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1, 1'b1);
    send_item(8'h41, 1'b1, 1'b1, 1'b1);
    send_item(8'h01, 1'b1, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b1, 1'b1);
    send_item(8'hC0, 1'b1, 1'b1, 1'b1);
    send_item(8'hFE, 1'b1, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0, 1'b0);   // zero block, last item carries no byte
    send_item(8'h00, 1'b0, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1, 1'b0);
    send_block(20, 4);                     // text
    send_block(12, 3);                     // sparse
    send_block(8, 1);                      // repeat
    drain();
  endtask

  task automatic test_entropy_bands();
    send_block(64, 5);
    send_block(40, 2);
    send_block(30, 6);
    for (int i = 0; i < 256; i++) send_item(i[7:0], 1'b1, i == 255, 1'b0, 1'b0);
    drain();
  endtask

  // Push past the block limit; the excess bytes must be dropped.
  task automatic test_overlong_block();
    for (int i = 0; i < BLK_MAX + 6; i++)
      send_item((i < BLK_MAX) ? 8'h00 : 8'h41, 1'b1, i == BLK_MAX + 5, 1'b0, 1'b0);
    drain();
  endtask

  // Hold the receiver off for a long stretch while blocks keep coming.
  task automatic test_backpressure();
    hold_off = 3000;
    for (int i = 0; i < 6; i++) send_block($urandom_range(1, 6), 0);
    drain();
  endtask

  task automatic test_random();
    int unsigned items;
    int unsigned len;
    items = 0;
    while (items < 200) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        items++;
      end else begin
        len = $urandom_range(1, 24);
        send_block(len, $urandom_range(0, 6), $urandom_range(0, 7) == 0);
        items += len;
      end
    end
    drain();
  endtask

  // Receiver: random stalls, plus the forced hold-off.
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off != 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else if (stall_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each result transfer against the oldest prediction.
  always @(posedge clk) begin
    class_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (class_q.size() == 0) begin
        $display("%0t: unexpected result color %0d kind %0d", $time,
                 color_index, kind_code);
        fail_count++;
      end else begin
        exp_c = class_q.pop_front();
        if (color_index !== exp_c.color) begin
          $display("%0t: color expected %0d actual %0d", $time, exp_c.color,
                   color_index);
          fail_count++;
        end
        if (kind_code !== exp_c.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_c.kind,
                   kind_code);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    data_byte = 8'h00;
    byte_valid = 1'b0;
    last_flag = 1'b0;
    single_mode = 1'b0;
    fail_count = 0;
    hold_off = 0;
    stall_en = 1'b1;
    clear_block();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_entropy_bands();
    test_overlong_block();
    test_backpressure();
    test_random();
    // Let any trailing, unexpected result show up.
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && class_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
